// ----- rtl/jbcq_pkg.sv -----
// Shared types and constants for the joystick/button command qualifier.
// Holds command codes, item kinds, register indexes and the work descriptor.
// No dependencies.
package jbcq_pkg;

  // Command codes carried in result frames
  localparam logic [7:0] CODE_HOME  = 8'h00;
  localparam logic [7:0] CODE_DOWN  = 8'h01;
  localparam logic [7:0] CODE_LEFT  = 8'h02;
  localparam logic [7:0] CODE_RIGHT = 8'h03;
  localparam logic [7:0] CODE_UP    = 8'h04;
  localparam logic [7:0] CODE_BLANK = 8'hFF;

  // Input item kinds
  localparam logic [1:0] KIND_TICK       = 2'd0;
  localparam logic [1:0] KIND_CONNECT    = 2'd1;
  localparam logic [1:0] KIND_DISCONNECT = 2'd2;

  // Configuration register indexes
  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned CFG_DATA_W  = 16;
  localparam logic [CFG_INDEX_W-1:0] REG_CENTER_X      = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_CENTER_Y      = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_DIR_THRESHOLD = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_DEBOUNCE      = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_LONG_PRESS    = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_SEND_INTERVAL = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_STICK_INTERVAL = 3'd6;
  localparam logic [CFG_INDEX_W-1:0] REG_BLANK_REPEAT  = 3'd7;

  // Register reset values
  localparam logic [11:0] CENTER_RESET         = 12'd2048;
  localparam logic [11:0] THRESHOLD_RESET      = 12'd350;
  localparam logic [7:0]  DEBOUNCE_RESET       = 8'd15;
  localparam logic [15:0] LONG_PRESS_RESET     = 16'd2000;
  localparam logic [7:0]  SEND_INTERVAL_RESET  = 8'd20;
  localparam logic [7:0]  STICK_INTERVAL_RESET = 8'd2;
  localparam logic [3:0]  BLANK_REPEAT_RESET   = 4'd5;

  // Descriptor queue depth
  localparam int unsigned QUEUE_DEPTH = 2;

  // Result work for one tick, emitted in field order by the back end
  typedef struct packed {
    logic       home;          // home frame from a short press
    logic [3:0] blanks;        // blank frames from a long press
    logic       sleep;         // sleep request after the blanks
    logic       stick;         // frame for a new stick direction
    logic [7:0] stick_code;
    logic       periodic;      // periodic repeat of the latched command
    logic [7:0] periodic_code;
  } desc_t;

endpackage

// ----- rtl/joystick_button_command_qualifier.sv -----
// Top level of the joystick/button command qualifier.
// Instantiates jbcq_front, jbcq_queue and jbcq_back; depends on jbcq_pkg.
//
// Usage:
//   s_axis carries one item per transaction: tuser holds the kind (tick,
//   link connected, link disconnected), tdata the two stick samples and the
//   raw button level. m_axis carries results: tdata is the command code,
//   tuser the frame and sleep flags, tlast marks the final result of an item.
//   cfg writes one register per transaction (index, data); cfg_ready is
//   always high. Write registers only while the block is idle.
// Path: the first result of a tick passes the queue write at the accepting
//   edge, the back-end load and the output register before it shows on m_axis.
// Throughput: the front end takes one item per cycle while the queue has
//   room; the back end puts out one result per cycle while m_axis_tready
//   allows it, and a tick yields up to 18 results. The output register
//   is the limiting stage.
// Reset: registers return to their defaults, link is down, the latched
//   command is blank, the queue and output register are empty.
// Stall: when m_axis_tready is low the current result holds; the queue keeps
//   taking items until its two entries are full, then s_axis_tready drops.
module joystick_button_command_qualifier import jbcq_pkg::*; #(
  parameter int SAMPLE_BITS  = 12,
  parameter int COUNTER_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  // input stream
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // [SAMPLE_BITS-1:0] x_sample, [2*SAMPLE_BITS-1:SAMPLE_BITS] y_sample,
  // [2*SAMPLE_BITS] button_level, zero fill above
  input  logic [((2*SAMPLE_BITS+8)/8)*8-1:0] s_axis_tdata,
  input  logic [1:0]             s_axis_tuser,   // [1:0] kind
  // result stream
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [7:0]             m_axis_tdata,   // [7:0] command_code
  output logic [1:0]             m_axis_tuser,   // [0] frame_valid, [1] sleep_request
  output logic                   m_axis_tlast,   // last
  // register writes
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  logic  accept;
  logic  push, full, pop, head_valid;
  desc_t desc, head;

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = !full;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // classify each transaction and update button/stick/repeat state
  jbcq_front #(
    .SAMPLE_BITS  (SAMPLE_BITS),
    .COUNTER_BITS (COUNTER_BITS)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_valid && cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .take         (accept),
    .kind         (s_axis_tuser),
    .x_sample     (s_axis_tdata[SAMPLE_BITS-1:0]),
    .y_sample     (s_axis_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]),
    .button_level (s_axis_tdata[2*SAMPLE_BITS]),
    .push         (push),
    .desc         (desc)
  );

  // items that produce no result never enter the queue
  jbcq_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  (desc),
    .full       (full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  // serialize results in order: home, blanks, sleep, stick, repeat
  jbcq_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_code   (m_axis_tdata),
    .out_flags  (m_axis_tuser),
    .out_last   (m_axis_tlast)
  );

endmodule

// ----- rtl/jbcq_front.sv -----
// Front end: configuration registers, debounce, long press, stick and repeat timing.
// Classifies each accepted item into a result descriptor. Depends on jbcq_pkg.
module jbcq_front import jbcq_pkg::*; #(
  parameter int SAMPLE_BITS  = 12,
  parameter int COUNTER_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   take,
  input  logic [1:0]             kind,
  input  logic [SAMPLE_BITS-1:0] x_sample,
  input  logic [SAMPLE_BITS-1:0] y_sample,
  input  logic                   button_level,
  output logic                   push,
  output desc_t                  desc
);

  localparam int CW  = (COUNTER_BITS > 16) ? COUNTER_BITS : 16;
  localparam int DW  = ((SAMPLE_BITS > 12) ? SAMPLE_BITS : 12) + 1;
  localparam int CXW = DW - 1;

  // configuration; rest values are at least 12 bits so the 2048 default fits
  logic [CXW-1:0] center_x, center_y;
  logic [11:0] threshold;
  logic [7:0]  debounce_ticks, send_interval, stick_interval;
  logic [15:0] long_press_ticks;
  logic [3:0]  blank_repeat;

  // state
  logic                    link_up, link_up_next;
  logic [7:0]              latched, latched_next;
  logic                    raw_prev, raw_prev_next;
  logic                    stable, stable_next;
  logic [COUNTER_BITS-1:0] since_raw, since_raw_next;
  logic [COUNTER_BITS-1:0] since_press, since_press_next;
  logic                    long_done, long_done_next;
  logic [COUNTER_BITS-1:0] since_send, since_send_next;
  logic [7:0]              since_stick, since_stick_next;

  // stick classification
  logic signed [DW-1:0] dx, dy, ax, ay, thr;
  logic                 dir_hit;
  logic [7:0]           dir_code;

  function automatic logic [COUNTER_BITS-1:0] sat_inc(input logic [COUNTER_BITS-1:0] v);
    return (&v) ? v : v + 1'b1;
  endfunction

  function automatic logic cnt_ge(input logic [COUNTER_BITS-1:0] a, input logic [15:0] b);
    return CW'(a) >= CW'(b);
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      center_x         <= CXW'(CENTER_RESET);
      center_y         <= CXW'(CENTER_RESET);
      threshold        <= THRESHOLD_RESET;
      debounce_ticks   <= DEBOUNCE_RESET;
      long_press_ticks <= LONG_PRESS_RESET;
      send_interval    <= SEND_INTERVAL_RESET;
      stick_interval   <= STICK_INTERVAL_RESET;
      blank_repeat     <= BLANK_REPEAT_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_CENTER_X:       center_x         <= CXW'(cfg_data[SAMPLE_BITS-1:0]);
        REG_CENTER_Y:       center_y         <= CXW'(cfg_data[SAMPLE_BITS-1:0]);
        REG_DIR_THRESHOLD:  threshold        <= cfg_data[11:0];
        REG_DEBOUNCE:       debounce_ticks   <= cfg_data[7:0];
        REG_LONG_PRESS:     long_press_ticks <= cfg_data[15:0];
        REG_SEND_INTERVAL:  send_interval    <= cfg_data[7:0];
        REG_STICK_INTERVAL: stick_interval   <= cfg_data[7:0];
        REG_BLANK_REPEAT:   blank_repeat     <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // dominant axis; vertical wins a tie
  always_comb begin
    dx  = $signed(DW'(x_sample)) - $signed(DW'(center_x));
    dy  = $signed(DW'(y_sample)) - $signed(DW'(center_y));
    ax  = dx[DW-1] ? -dx : dx;
    ay  = dy[DW-1] ? -dy : dy;
    thr = $signed(DW'(threshold));
    if (ax > ay) begin
      dir_hit  = ax > thr;
      dir_code = dx[DW-1] ? CODE_LEFT : CODE_RIGHT;
    end else begin
      dir_hit  = ay > thr;
      dir_code = dy[DW-1] ? CODE_UP : CODE_DOWN;
    end
  end

  always_comb begin
    link_up_next     = link_up;
    latched_next     = latched;
    raw_prev_next    = raw_prev;
    stable_next      = stable;
    since_raw_next   = since_raw;
    since_press_next = since_press;
    long_done_next   = long_done;
    since_send_next  = since_send;
    since_stick_next = since_stick;
    desc             = '0;
    push             = 1'b0;
    if (take) begin
      case (kind)
        KIND_CONNECT: begin
          link_up_next    = 1'b1;
          latched_next    = CODE_BLANK;
          since_send_next = '1;
        end
        KIND_DISCONNECT: begin
          link_up_next = 1'b0;
          latched_next = CODE_BLANK;
        end
        KIND_TICK: begin
          since_raw_next   = sat_inc(since_raw);
          since_press_next = sat_inc(since_press);
          since_send_next  = sat_inc(since_send);
          since_stick_next = (&since_stick) ? since_stick : since_stick + 8'd1;

          // debounce
          if (button_level != raw_prev) begin
            raw_prev_next  = button_level;
            since_raw_next = '0;
          end
          if (cnt_ge(since_raw_next, 16'(debounce_ticks)) && button_level != stable) begin
            stable_next = button_level;
            if (!button_level) begin
              since_press_next = '0;
              long_done_next   = 1'b0;
            end else begin
              if (!long_done && latched_next != CODE_HOME) begin
                latched_next    = CODE_HOME;
                desc.home       = link_up;
                since_send_next = '0;
              end
              long_done_next = 1'b0;
            end
          end

          // long press: blanks then sleep request
          if (!stable_next && !long_done_next &&
              cnt_ge(since_press_next, long_press_ticks)) begin
            long_done_next = 1'b1;
            latched_next   = CODE_BLANK;
            desc.blanks    = link_up ? blank_repeat : 4'd0;
            desc.sleep     = 1'b1;
          end

          // stick sampling
          if (since_stick_next >= stick_interval) begin
            since_stick_next = '0;
            if (dir_hit && latched_next != dir_code) begin
              latched_next    = dir_code;
              desc.stick      = link_up;
              desc.stick_code = dir_code;
              since_send_next = '0;
            end
          end

          // periodic repeat
          if (link_up && cnt_ge(since_send_next, 16'(send_interval))) begin
            since_send_next    = '0;
            desc.periodic      = 1'b1;
            desc.periodic_code = latched_next;
          end

          push = desc.home || (desc.blanks != 4'd0) || desc.sleep ||
                 desc.stick || desc.periodic;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      link_up     <= 1'b0;
      latched     <= CODE_BLANK;
      raw_prev    <= 1'b1;
      stable      <= 1'b1;
      since_raw   <= '0;
      since_press <= '0;
      long_done   <= 1'b0;
      since_send  <= '0;
      since_stick <= '0;
    end else begin
      link_up     <= link_up_next;
      latched     <= latched_next;
      raw_prev    <= raw_prev_next;
      stable      <= stable_next;
      since_raw   <= since_raw_next;
      since_press <= since_press_next;
      long_done   <= long_done_next;
      since_send  <= since_send_next;
      since_stick <= since_stick_next;
    end
  end

endmodule

// ----- rtl/jbcq_queue.sv -----
// Short descriptor queue between front and back end.
// Register based, QUEUE_DEPTH entries. Depends on jbcq_pkg.
module jbcq_queue import jbcq_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  desc_t push_data,
  output logic  full,
  input  logic  pop,
  output logic  head_valid,
  output desc_t head
);

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int NW = $clog2(QUEUE_DEPTH + 1);

  desc_t           entries [QUEUE_DEPTH];
  logic [PW-1:0]   wr_ptr, rd_ptr;
  logic [NW-1:0]   fill;
  logic            do_push, do_pop;

  assign full       = (fill == NW'(QUEUE_DEPTH));
  assign head_valid = (fill != '0);
  assign head       = entries[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      fill <= fill + NW'(do_push) - NW'(do_pop);
    end
  end

endmodule

// ----- rtl/jbcq_back.sv -----
// Back end: expands one descriptor into a serial run of results.
// One result per cycle into the output register while out_ready allows it. Depends on jbcq_pkg.
module jbcq_back import jbcq_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       head_valid,
  input  desc_t      head,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_code,
  output logic [1:0] out_flags,   // [0] frame_valid, [1] sleep_request
  output logic       out_last
);

  logic       active;
  logic       home, sleep, stick, periodic;
  logic [3:0] blanks;
  logic [7:0] stick_code, periodic_code;

  logic       home_next, sleep_next, stick_next, periodic_next;
  logic [3:0] blanks_next;
  logic       advance, finish;
  logic [7:0] sel_code;
  logic       sel_frame, sel_sleep;

  assign advance = active && (!out_valid || out_ready);
  assign pop     = head_valid && (!active || (advance && finish));

  // pick the next result in emission order
  always_comb begin
    home_next     = home;
    blanks_next   = blanks;
    sleep_next    = sleep;
    stick_next    = stick;
    periodic_next = periodic;
    sel_frame     = 1'b1;
    sel_sleep     = 1'b0;
    sel_code      = periodic_code;
    if (home) begin
      home_next = 1'b0;
      sel_code  = CODE_HOME;
    end else if (blanks != 4'd0) begin
      blanks_next = blanks - 4'd1;
      sel_code    = CODE_BLANK;
    end else if (sleep) begin
      sleep_next = 1'b0;
      sel_frame  = 1'b0;
      sel_sleep  = 1'b1;
      sel_code   = CODE_BLANK;
    end else if (stick) begin
      stick_next = 1'b0;
      sel_code   = stick_code;
    end else begin
      periodic_next = 1'b0;
    end
    finish = !(home_next || (blanks_next != 4'd0) || sleep_next ||
               stick_next || periodic_next);
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      home          <= head.home;
      blanks        <= head.blanks;
      sleep         <= head.sleep;
      stick         <= head.stick;
      stick_code    <= head.stick_code;
      periodic      <= head.periodic;
      periodic_code <= head.periodic_code;
    end else if (advance) begin
      home     <= home_next;
      blanks   <= blanks_next;
      sleep    <= sleep_next;
      stick    <= stick_next;
      periodic <= periodic_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
    end else if (pop) begin
      active <= 1'b1;
    end else if (advance && finish) begin
      active <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_code  <= sel_code;
      out_flags <= {sel_sleep, sel_frame};
      out_last  <= finish;
    end
  end

endmodule

// ----- tb/sv/tb_joystick_button_command_qualifier.sv -----
// Self-checking bench for joystick_button_command_qualifier: streams ticks and
// link events, predicts commands, frames and sleep requests, checks m_axis.
// Depends on jbcq_pkg and the RTL top level only.
`timescale 1ns / 100ps

module tb_joystick_button_command_qualifier import jbcq_pkg::*;;

  localparam logic [1:0] KIND_UNUSED = 2'd3;  // ignored by the block
  localparam int CYCLE_LIMIT = 600000;
  localparam int MAX_PER_TICK = 18;

  typedef struct packed {
    logic [1:0]  kind;
    logic [11:0] x_s;
    logic [11:0] y_s;
    logic        btn;
  } stick_item_t;

  typedef struct packed {
    logic       frame;
    logic [7:0] code;
    logic       sleep;
    logic       last;
  } result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;   // [11:0] x, [23:12] y, [24] button, zero fill
  logic [1:0]  s_axis_tuser = '0;   // [1:0] kind
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;        // [7:0] command code
  logic [1:0]  m_axis_tuser;        // [0] frame valid, [1] sleep request
  logic        m_axis_tlast;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  joystick_button_command_qualifier dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Bench-side copy of the register file
  logic [11:0] rest_x, rest_y, dead_band;
  logic [7:0]  debounce_len, repeat_gap, stick_gap;
  logic [15:0] long_len;
  logic [3:0]  blank_count;

  // Bench-side copy of the qualifier state
  logic        link_is_up, raw_last, btn_stable, long_fired;
  logic [7:0]  cur_cmd, stick_age;
  logic [15:0] raw_age, press_age, send_age;

  stick_item_t items_to_send[$];
  result_t     results_due[$];
  result_t     tick_out[0:MAX_PER_TICK-1];
  int          tick_n;
  stick_item_t in_flight;
  result_t     due;
  int          mismatch_count = 0;
  int          cycle_count = 0;
  logic        calm = 1'b0;   // no idling on either side while set

  task automatic flag_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $time, msg);
    mismatch_count++;
  endtask

  function automatic void note_result(logic frame, logic [7:0] code, logic sleep);
    tick_out[tick_n] = '{frame: frame, code: code, sleep: sleep, last: 1'b0};
    tick_n++;
  endfunction

  function automatic void send_cmd(logic [7:0] code);
    if (link_is_up) note_result(1'b1, code, 1'b0);
  endfunction

  // A changed command goes out at once if the link is up, and restarts the repeat timer
  function automatic void switch_cmd(logic [7:0] code);
    if (cur_cmd != code) begin
      cur_cmd = code;
      send_cmd(code);
      send_age = '0;
    end
  endfunction

  // Advance the state by one accepted transaction and queue what it yields
  function automatic void qualify_item(stick_item_t it);
    int i, dx, dy, ax, ay, band;
    result_t r;
    tick_n = 0;
    case (it.kind)
      KIND_CONNECT: begin
        link_is_up = 1'b1;
        cur_cmd = CODE_BLANK;
        send_age = '1;   // first tick after connect repeats at once
      end
      KIND_DISCONNECT: begin
        link_is_up = 1'b0;
        cur_cmd = CODE_BLANK;
      end
      KIND_TICK: begin
        if (raw_age != '1) raw_age++;
        if (press_age != '1) press_age++;
        if (send_age != '1) send_age++;
        if (stick_age != '1) stick_age++;
        // debounce
        if (it.btn != raw_last) begin
          raw_last = it.btn;
          raw_age = '0;
        end
        if (raw_age >= 16'(debounce_len) && it.btn != btn_stable) begin
          btn_stable = it.btn;
          if (!btn_stable) begin
            press_age = '0;
            long_fired = 1'b0;
          end else begin
            if (!long_fired) switch_cmd(CODE_HOME);
            long_fired = 1'b0;
          end
        end
        // long press: blank burst, then the sleep request even with link down
        if (!btn_stable && !long_fired && press_age >= long_len) begin
          long_fired = 1'b1;
          cur_cmd = CODE_BLANK;
          for (i = 0; i < int'(blank_count); i++) send_cmd(CODE_BLANK);
          note_result(1'b0, CODE_BLANK, 1'b1);
        end
        // stick, sampled every stick_gap ticks; ties go to the vertical axis
        if (stick_age >= stick_gap) begin
          stick_age = '0;
          dx = int'(it.x_s) - int'(rest_x);
          dy = int'(it.y_s) - int'(rest_y);
          band = int'(dead_band);
          ax = dx < 0 ? -dx : dx;
          ay = dy < 0 ? -dy : dy;
          if (!(ax < band && ay < band)) begin
            if (ax > ay) begin
              if (dx < -band) switch_cmd(CODE_LEFT);
              else if (dx > band) switch_cmd(CODE_RIGHT);
            end else begin
              if (dy < -band) switch_cmd(CODE_UP);
              else if (dy > band) switch_cmd(CODE_DOWN);
            end
          end
        end
        if (link_is_up && send_age >= 16'(repeat_gap)) begin
          send_age = '0;
          send_cmd(cur_cmd);
        end
      end
      default: ;
    endcase
    for (i = 0; i < tick_n; i++) begin
      r = tick_out[i];
      r.last = (i == tick_n - 1);
      results_due.push_back(r);
    end
  endfunction

  function automatic void store_reg(logic [CFG_INDEX_W-1:0] idx, logic [15:0] val);
    case (idx)
      REG_CENTER_X:       rest_x = val[11:0];
      REG_CENTER_Y:       rest_y = val[11:0];
      REG_DIR_THRESHOLD:  dead_band = val[11:0];
      REG_DEBOUNCE:       debounce_len = val[7:0];
      REG_LONG_PRESS:     long_len = val;
      REG_SEND_INTERVAL:  repeat_gap = val[7:0];
      REG_STICK_INTERVAL: stick_gap = val[7:0];
      REG_BLANK_REPEAT:   blank_count = val[3:0];
      default: ;
    endcase
  endfunction

  // Driver: presents queued items, predicts each one as it is accepted
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) qualify_item(in_flight);
      if (!s_axis_tvalid || s_axis_tready) begin
        if (items_to_send.size() != 0 && (calm || $urandom_range(99) >= 34)) begin
          in_flight = items_to_send.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= {7'b0, in_flight.btn, in_flight.y_s, in_flight.x_s};
          s_axis_tuser <= in_flight.kind;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each result transaction against the oldest prediction
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (results_due.size() == 0) begin
          flag_mismatch($sformatf("unexpected result code=%0h user=%b last=%b",
                                  m_axis_tdata, m_axis_tuser, m_axis_tlast));
        end else begin
          due = results_due.pop_front();
          if (m_axis_tuser[0] !== due.frame || m_axis_tdata !== due.code ||
              m_axis_tuser[1] !== due.sleep || m_axis_tlast !== due.last)
            flag_mismatch($sformatf(
              "frame %b/%b code %0h/%0h sleep %b/%b last %b/%b (got/want)",
              m_axis_tuser[0], due.frame, m_axis_tdata, due.code,
              m_axis_tuser[1], due.sleep, m_axis_tlast, due.last));
        end
      end
      m_axis_tready <= calm || ($urandom_range(99) >= 34);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic void queue_item(logic [1:0] k, logic [11:0] xs, logic [11:0] ys,
                                     logic b);
    items_to_send.push_back('{kind: k, x_s: xs, y_s: ys, btn: b});
  endfunction

  // Sample around a rest value: inside the band, beyond it, on its edge,
  // anywhere, or at the converter limits
  function automatic logic [11:0] pick_sample(logic [11:0] rest, logic [11:0] band);
    int c, b, v;
    c = int'(rest);
    b = int'(band);
    case ($urandom_range(5))
      0: v = (b > 0) ? c + int'($urandom_range(2 * (b - 1))) - (b - 1) : c;
      1: v = c + b + int'($urandom_range(400, 1));
      2: v = c - b - int'($urandom_range(400, 1));
      3: v = $urandom_range(1) ? c + b : c - b;
      4: v = int'($urandom_range(4095));
      default: v = $urandom_range(1) ? 4095 : 0;
    endcase
    if (v < 0) v = 0;
    if (v > 4095) v = 4095;
    return v[11:0];
  endfunction

  // Well-formed activity: alternating press/release runs sized around the
  // debounce and long-press settings, held stick positions, rare link events
  task automatic queue_activity(input int count);
    int made, btn_left, stick_left, len, off;
    logic btn_lvl;
    logic [11:0] xs, ys;
    made = 0;
    btn_left = 0;
    stick_left = 0;
    btn_lvl = 1'b1;
    xs = rest_x;
    ys = rest_y;
    while (made < count) begin
      case ($urandom_range(99))
        0, 1: queue_item(KIND_UNUSED, 12'($urandom), 12'($urandom), 1'($urandom));
        2, 3, 4: begin
          queue_item(KIND_CONNECT, 12'($urandom), 12'($urandom), 1'($urandom));
          made++;
        end
        5: begin
          queue_item(KIND_DISCONNECT, 12'($urandom), 12'($urandom), 1'($urandom));
          made++;
        end
        default: begin
          if (btn_left == 0) begin
            btn_lvl = ~btn_lvl;
            case ($urandom_range(9))
              0, 1:    len = $urandom_range(2, 1);                      // bounce
              2, 3, 4: len = int'(debounce_len) + $urandom_range(4, 1); // short
              5, 6:    len = int'(debounce_len) + int'(long_len) + $urandom_range(3, 1);
              default: len = $urandom_range(10, 1);
            endcase
            btn_left = len > 200 ? 200 : len;
          end
          if (stick_left == 0) begin
            xs = pick_sample(rest_x, dead_band);
            ys = pick_sample(rest_y, dead_band);
            if ($urandom_range(7) == 0) begin   // equal deflection on both axes
              off = int'(xs) - int'(rest_x);
              off = off < 0 ? -off : off;
              off = $urandom_range(1) ? int'(rest_y) + off : int'(rest_y) - off;
              if (off >= 0 && off <= 4095) ys = off[11:0];
            end
            stick_left = $urandom_range(8, 1);
          end
          queue_item(KIND_TICK, xs, ys, btn_lvl);
          btn_left--;
          stick_left--;
          made++;
        end
      endcase
    end
  endtask

  // Wait until nothing is queued, in flight or expected, then let the
  // pipeline settle past any item that yields no result
  task automatic wait_idle;
    do @(negedge clk);
    while (items_to_send.size() != 0 || s_axis_tvalid || results_due.size() != 0);
    repeat (12) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [15:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk);
    while (!cfg_ready);
    store_reg(idx, val);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_config(input int cx, input int cy, input int band, input int deb,
                            input int lp, input int gap, input int sgap, input int blanks);
    write_reg(REG_CENTER_X, 16'(cx));
    write_reg(REG_CENTER_Y, 16'(cy));
    write_reg(REG_DIR_THRESHOLD, 16'(band));
    write_reg(REG_DEBOUNCE, 16'(deb));
    write_reg(REG_LONG_PRESS, 16'(lp));
    write_reg(REG_SEND_INTERVAL, 16'(gap));
    write_reg(REG_STICK_INTERVAL, 16'(sgap));
    write_reg(REG_BLANK_REPEAT, 16'(blanks));
    @(negedge clk);
  endtask

  task automatic set_moderate_config(input int gap, input int sgap);
    set_config($urandom_range(2600, 1500), $urandom_range(2600, 1500),
               $urandom_range(600, 50), $urandom_range(4), $urandom_range(25, 3),
               gap, sgap, $urandom_range(15));
  endtask

  task automatic run_phase(input int count);
    queue_item(KIND_CONNECT, 12'($urandom), 12'($urandom), 1'b1);
    queue_activity(count - 1);
    wait_idle();
  endtask

  initial begin
    // reset values of registers and state
    rest_x = 12'd2048;
    rest_y = 12'd2048;
    dead_band = THRESHOLD_RESET;
    debounce_len = DEBOUNCE_RESET;
    long_len = LONG_PRESS_RESET;
    repeat_gap = SEND_INTERVAL_RESET;
    stick_gap = STICK_INTERVAL_RESET;
    blank_count = BLANK_REPEAT_RESET;
    link_is_up = 1'b0;
    cur_cmd = CODE_BLANK;
    raw_last = 1'b1;
    btn_stable = 1'b1;
    long_fired = 1'b0;
    raw_age = '0;
    press_age = '0;
    send_age = '0;
    stick_age = '0;

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed, reset configuration: latching with link down (tie goes up),
    // immediate repeat after connect, right deflection, ignored kind
    queue_item(KIND_TICK, 12'd0, 12'd0, 1'b1);
    queue_item(KIND_TICK, 12'd0, 12'd0, 1'b1);
    queue_item(KIND_CONNECT, 12'd0, 12'd0, 1'b1);
    queue_item(KIND_TICK, 12'd4095, 12'd2048, 1'b1);
    queue_item(KIND_TICK, 12'd4095, 12'd2048, 1'b1);
    queue_item(KIND_UNUSED, 12'hFFF, 12'hFFF, 1'b1);
    queue_item(KIND_DISCONNECT, 12'd0, 12'd0, 1'b0);
    wait_idle();

    // Directed, short timings: edge of the threshold, left, tie, long press
    // with the full blank burst, release after long press, short press home,
    // long press with link down giving a bare sleep request
    set_config(1000, 3000, 100, 0, 3, 255, 1, 15);
    queue_item(KIND_CONNECT, 12'd0, 12'd0, 1'b1);
    queue_item(KIND_TICK, 12'd1000, 12'd3000, 1'b1);
    queue_item(KIND_TICK, 12'd1100, 12'd3000, 1'b1);
    queue_item(KIND_TICK, 12'd899, 12'd3000, 1'b1);
    queue_item(KIND_TICK, 12'd1150, 12'd2850, 1'b1);
    queue_item(KIND_TICK, 12'd1000, 12'd3000, 1'b0);
    queue_item(KIND_TICK, 12'd1000, 12'd3000, 1'b0);
    queue_item(KIND_TICK, 12'd1000, 12'd3000, 1'b0);
    queue_item(KIND_TICK, 12'd1200, 12'd3000, 1'b0);
    queue_item(KIND_TICK, 12'd1000, 12'd3000, 1'b1);
    queue_item(KIND_TICK, 12'd1000, 12'd3000, 1'b0);
    queue_item(KIND_TICK, 12'd1000, 12'd3000, 1'b1);
    queue_item(KIND_TICK, 12'd4095, 12'd0, 1'b0);
    queue_item(KIND_DISCONNECT, 12'd0, 12'd0, 1'b0);
    queue_item(KIND_TICK, 12'd1000, 12'd3000, 1'b0);
    queue_item(KIND_TICK, 12'd1000, 12'd3000, 1'b0);
    queue_item(KIND_TICK, 12'd1000, 12'd3000, 1'b0);
    queue_item(KIND_TICK, 12'd1000, 12'd3000, 1'b1);
    wait_idle();

    // Random phases; the first pauses midway until all results have drained
    set_moderate_config($urandom_range(30, 2), $urandom_range(4, 1));
    queue_item(KIND_CONNECT, 12'd0, 12'd0, 1'b1);
    queue_activity(40);
    wait_idle();
    queue_activity(40);
    wait_idle();

    set_config(0, 0, 0, 0, 1, 1, 1, 0);
    run_phase(50);

    set_config(4095, 4095, 4095, 255, 65535, 255, 255, 15);
    run_phase(40);

    // zero intervals: every comparison against them holds
    set_moderate_config(0, 0);
    run_phase(50);

    set_moderate_config($urandom_range(30, 2), $urandom_range(4, 1));
    calm = 1'b1;
    run_phase(120);
    calm = 1'b0;

    set_moderate_config($urandom_range(255, 1), $urandom_range(255, 1));
    run_phase(20);
    set_moderate_config($urandom_range(30, 2), $urandom_range(4, 1));
    run_phase(100);

    repeat (20) @(posedge clk);
    if (mismatch_count == 0 && results_due.size() == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
